### sv/ghist_pkg.sv
// Package for the green channel histogram unit.
// Holds sizes, op codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package ghist_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int COUNT_BITS = 24;
  localparam int PCT_BITS   = 7;
  localparam int PCT_SCALE  = 100;
  localparam int PROD_BITS  = COUNT_BITS + PCT_BITS;
  localparam int DIV_STEPS  = PCT_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);
  localparam int FIELD_BITS = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_RD_RD,
    S_RD_MUL,
    S_RD_DIV,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mem_rd_add;
    logic mem_rd_read;
    logic add_wr;
    logic mul;
    logic div_step;
    logic out_load;
  } ghist_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } ghist_stat_t;

endpackage

`default_nettype wire

### sv/ghist_ctrl.sv
// Controller state machine of the green channel histogram unit.
// Sequences clear, add and read transactions; depends on ghist_pkg.
`default_nettype none

module ghist_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire ghist_pkg::ghist_stat_t stat,
  output ghist_pkg::ghist_cmd_t   cmd
);

  ghist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ghist_pkg::S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          case (ghist_pkg::op_t'(op))
            ghist_pkg::OP_CLEAR: cmd.clear = 1'b1;
            ghist_pkg::OP_ADD:   state_next = ghist_pkg::S_ADD_RD;
            ghist_pkg::OP_READ:  state_next = ghist_pkg::S_RD_RD;
            default:             state_next = ghist_pkg::S_IDLE;
          endcase
        end
      end
      ghist_pkg::S_ADD_RD: begin
        cmd.mem_rd_add = 1'b1;
        state_next     = ghist_pkg::S_ADD_WR;
      end
      ghist_pkg::S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = ghist_pkg::S_IDLE;
      end
      ghist_pkg::S_RD_RD: begin
        cmd.mem_rd_read = 1'b1;
        state_next      = ghist_pkg::S_RD_MUL;
      end
      ghist_pkg::S_RD_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ghist_pkg::S_RD_DIV;
      end
      ghist_pkg::S_RD_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ghist_pkg::S_RD_OUT;
        end
      end
      ghist_pkg::S_RD_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ghist_pkg::S_IDLE;
        end
      end
      default: state_next = ghist_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/ghist_datapath.sv
// Datapath of the green channel histogram unit: bin memory with valid bits,
// pixel total, percent multiply and restoring divider, output register.
// Depends on ghist_pkg.
`default_nettype none

module ghist_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ghist_pkg::ghist_cmd_t              cmd,
  output ghist_pkg::ghist_stat_t                  stat,
  input  wire logic [ghist_pkg::FIELD_BITS-1:0]   green_value,
  input  wire logic [ghist_pkg::FIELD_BITS-1:0]   bin_index,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ghist_pkg::COUNT_BITS-1:0]        out_count,
  output logic [ghist_pkg::PCT_BITS-1:0]          out_pct
);

  localparam logic [ghist_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ghist_pkg::PCT_BITS-1:0] PCT_MAX =
    ghist_pkg::PCT_BITS'(ghist_pkg::PCT_SCALE);
  localparam logic [ghist_pkg::STEP_BITS-1:0] STEP_FIRST =
    ghist_pkg::STEP_BITS'(ghist_pkg::DIV_STEPS - 1);

  function automatic logic [ghist_pkg::COUNT_BITS-1:0] sat_inc(
    input logic [ghist_pkg::COUNT_BITS-1:0] v
  );
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  logic [ghist_pkg::COUNT_BITS-1:0] mem [ghist_pkg::BIN_COUNT];
  logic [ghist_pkg::BIN_COUNT-1:0]  bin_valid;
  logic [ghist_pkg::COUNT_BITS-1:0] mem_q;
  logic                             valid_q;
  logic [ghist_pkg::COUNT_BITS-1:0] rd_val;

  logic [ghist_pkg::BIN_BITS-1:0]   add_bin;
  logic [ghist_pkg::BIN_BITS-1:0]   read_bin;
  logic                             read_ok;
  logic [ghist_pkg::BIN_BITS-1:0]   rd_addr;

  logic [ghist_pkg::COUNT_BITS-1:0] total;
  logic [ghist_pkg::COUNT_BITS-1:0] cnt;
  logic                             pct_zero;
  logic [ghist_pkg::PROD_BITS-1:0]  rem;
  logic [ghist_pkg::PROD_BITS-1:0]  dvs;
  logic [ghist_pkg::PCT_BITS-1:0]   quot;
  logic [ghist_pkg::STEP_BITS-1:0]  step;
  logic                             ge;

  assign rd_val  = valid_q ? mem_q : '0;
  assign rd_addr = cmd.mem_rd_add ? add_bin : read_bin;
  assign ge      = (rem >= dvs);

  assign stat.div_last = (step == '0);
  assign stat.out_busy = out_valid && !out_ready;

  // Latch the transaction fields; green values past the last bin fold into it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (int'(green_value) >= ghist_pkg::BIN_COUNT) begin
        add_bin <= ghist_pkg::BIN_BITS'(ghist_pkg::BIN_COUNT - 1);
      end else begin
        add_bin <= ghist_pkg::BIN_BITS'(green_value);
      end
      read_bin <= ghist_pkg::BIN_BITS'(bin_index);
      read_ok  <= (int'(bin_index) < ghist_pkg::BIN_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd_add || cmd.mem_rd_read) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[add_bin] <= sat_inc(rd_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bin_valid <= '0;
      total     <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cmd.mem_rd_add || cmd.mem_rd_read) begin
        valid_q <= bin_valid[rd_addr];
      end
      if (cmd.add_wr) begin
        bin_valid[add_bin] <= 1'b1;
        total              <= sat_inc(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      cnt      <= read_ok ? rd_val : '0;
      pct_zero <= !read_ok || (total == '0);
      rem      <= ghist_pkg::PROD_BITS'(rd_val) *
                  ghist_pkg::PROD_BITS'(ghist_pkg::PCT_SCALE);
      dvs      <= ghist_pkg::PROD_BITS'(total) << STEP_FIRST;
      quot     <= '0;
      step     <= STEP_FIRST;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs  <= dvs >> 1;
      quot <= {quot[ghist_pkg::PCT_BITS-2:0], ge};
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count <= cnt;
      if (pct_zero) begin
        out_pct <= '0;
      end else if (quot > PCT_MAX) begin
        out_pct <= PCT_MAX;
      end else begin
        out_pct <= quot;
      end
    end
  end

endmodule

`default_nettype wire

### sv/green_channel_histogram_unit.sv
// Top level of the green channel histogram unit.
// Joins ghist_ctrl and ghist_datapath; depends on ghist_pkg.
//
// Usage:
//   Slave channel s_*: one transaction per op. s_tuser carries the op
//   (clear, add pixel, read bin); s_tdata carries green value and bin index.
//   Master channel m_*: one transaction per read bin, carrying the bin count
//   and its share of all pixels in whole percent.
//   The controller takes one op at a time, in these steps:
//     clear     accept (bins and total zeroed at the accepting edge)
//     add       accept, memory read, read-modify-write
//     read      accept, memory read, multiply by 100,
//               7 restoring divider steps, output load
//   A read result is visible on m_tvalid once the output load has registered it.
//   The output register parts both sides: new ops are accepted while a
//   result waits; a second read holds in its final state until m_tready.
//   Reset zeroes all bins at once through per-bin valid bits and the total;
//   s_tready rises as soon as reset drops.
`default_nettype none

module green_channel_histogram_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [7:0] green_value, [15:8] bin_index
  input  wire logic [1:0]  s_tuser,  // [1:0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // [23:0] bin_count, [30:24] percent, [31] zero
);

  ghist_pkg::ghist_cmd_t  cmd;
  ghist_pkg::ghist_stat_t stat;
  logic [ghist_pkg::COUNT_BITS-1:0] out_count;
  logic [ghist_pkg::PCT_BITS-1:0]   out_pct;

  ghist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  ghist_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .green_value (s_tdata[7:0]),
    .bin_index   (s_tdata[15:8]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_count   (out_count),
    .out_pct     (out_pct)
  );

  assign m_tdata = {1'b0, out_pct, out_count};

endmodule

`default_nettype wire

### tb/tb_green_channel_histogram_unit.sv
// Self-checking testbench for green_channel_histogram_unit.
// Tracks bin counts and the pixel total per transaction and checks every read result.
// Depends on ghist_pkg and the unit's RTL only.
`default_nettype none

module tb_green_channel_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ghist_pkg::COUNT_BITS-1:0] count;
    logic [ghist_pkg::PCT_BITS-1:0]   pct;
  } bin_report_t;

  localparam logic [ghist_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] green_value, [15:8] bin_index
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [23:0] bin_count, [30:24] percent, [31] zero

  logic [ghist_pkg::COUNT_BITS-1:0] bin_tally [ghist_pkg::BIN_COUNT];
  logic [ghist_pkg::COUNT_BITS-1:0] pixel_tally;
  bin_report_t                      reports_due[$];
  int unsigned                      mismatches = 0;
  bit                               quiet = 1'b0;

  green_channel_histogram_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  task automatic tally_op(ghist_pkg::op_t op, logic [7:0] green, logic [7:0] idx);
    bin_report_t rep;
    logic [63:0] share;
    int unsigned b;
    case (op)
      ghist_pkg::OP_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        pixel_tally = '0;
      end
      ghist_pkg::OP_ADD: begin
        b = (green >= ghist_pkg::BIN_COUNT) ? ghist_pkg::BIN_COUNT - 1 : green;
        if (bin_tally[b] != COUNT_MAX) bin_tally[b] = bin_tally[b] + 1'b1;
        if (pixel_tally != COUNT_MAX) pixel_tally = pixel_tally + 1'b1;
      end
      ghist_pkg::OP_READ: begin
        rep = '0;
        if (idx < ghist_pkg::BIN_COUNT) begin
          rep.count = bin_tally[idx];
          if (pixel_tally != 0) begin
            share = (64'(bin_tally[idx]) * ghist_pkg::PCT_SCALE) / 64'(pixel_tally);
            if (share > ghist_pkg::PCT_SCALE) share = ghist_pkg::PCT_SCALE;
            rep.pct = share[ghist_pkg::PCT_BITS-1:0];
          end
        end
        reports_due.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic pause(int unsigned n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_op(ghist_pkg::op_t op, logic [7:0] green, logic [7:0] idx);
    if (!quiet && $urandom_range(0, 7) == 0) pause($urandom_range(1, 18));
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {idx, green};
    do @(posedge clk); while (!s_tready);
    tally_op(op, green, idx);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall bursts unless quiet
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bin_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        if (m_tdata[23:0] !== want.count) begin
          $display("%0t: bin_count expected %0d actual %0d",
                   $time, want.count, m_tdata[23:0]);
          mismatches++;
        end
        if (m_tdata[30:24] !== want.pct) begin
          $display("%0t: percent expected %0d actual %0d",
                   $time, want.pct, m_tdata[30:24]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_after_reset();
    send_op(ghist_pkg::OP_READ, 8'h00, 8'h00);
    send_op(ghist_pkg::OP_READ, 8'hFF, 8'hFF);
  endtask

  task automatic test_ignored_op();
    send_op(ghist_pkg::OP_NOP, 8'hFF, 8'hFF);
    send_op(ghist_pkg::OP_NOP, 8'h00, 8'h00);
    send_op(ghist_pkg::OP_READ, 8'h5A, 8'h00);
  endtask

  task automatic test_field_extremes();
    send_op(ghist_pkg::OP_CLEAR, 8'hFF, 8'hFF);
    send_op(ghist_pkg::OP_ADD, 8'h00, 8'hFF);
    send_op(ghist_pkg::OP_ADD, 8'hFF, 8'h00);
    send_op(ghist_pkg::OP_READ, 8'hFF, 8'h00);
    send_op(ghist_pkg::OP_READ, 8'h00, 8'hFF);
  endtask

  task automatic test_shares();
    send_op(ghist_pkg::OP_CLEAR, 8'h00, 8'h00);
    repeat (3) send_op(ghist_pkg::OP_ADD, 8'h80, 8'h7F);
    send_op(ghist_pkg::OP_READ, 8'h01, 8'h80);
    send_op(ghist_pkg::OP_READ, 8'hFE, 8'h81);
    send_op(ghist_pkg::OP_ADD, 8'h00, 8'h55);
    send_op(ghist_pkg::OP_READ, 8'hAA, 8'h80);
    send_op(ghist_pkg::OP_READ, 8'h33, 8'h00);
  endtask

  task automatic test_sender_holdoff();
    send_op(ghist_pkg::OP_ADD, 8'h80, 8'h00);
    send_op(ghist_pkg::OP_READ, 8'h00, 8'h80);
    wait_drain();
    send_op(ghist_pkg::OP_READ, 8'h00, 8'h80);
  endtask

  // narrow green windows give nonzero counts and varied percentages
  task automatic test_random_stream(int unsigned n);
    int unsigned done;
    int unsigned r;
    logic [7:0]  center;
    int unsigned spread;
    logic [7:0]  green;
    logic [7:0]  idx;
    done = 0;
    center = '0;
    spread = 0;
    while (done < n) begin
      if (done % 40 == 0) begin
        center = 8'($urandom);
        spread = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 6);
      end
      r = $urandom_range(0, 99);
      green = 8'($urandom);
      idx = 8'($urandom);
      if (r < 1) begin
        send_op(ghist_pkg::OP_CLEAR, green, idx);
        done++;
      end else if (r < 62) begin
        send_op(ghist_pkg::OP_ADD, 8'(center + $urandom_range(0, spread)), idx);
        done++;
      end else if (r < 95) begin
        if ($urandom_range(0, 9) < 7) idx = 8'(center + $urandom_range(0, spread));
        send_op(ghist_pkg::OP_READ, green, idx);
        done++;
      end else begin
        send_op(ghist_pkg::OP_NOP, green, idx);
      end
    end
  endtask

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    pixel_tally = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_after_reset();
    test_ignored_op();
    test_field_extremes();
    test_shares();
    test_random_stream(300);
    test_sender_holdoff();
    test_random_stream(240);
    quiet = 1'b1;
    test_random_stream(60);
    wait_drain();
    repeat (24) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_green_channel_histogram_unit OK");
    end else begin
      $display("tb_green_channel_histogram_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_green_channel_histogram_unit NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
